// ===== sv/hsla_pkg.sv =====
`default_nettype none

package hsla_pkg;

  localparam int LIMB_COUNT    = 50;
  localparam int DENOM_BITS    = 20;
  localparam int DENOM_FIELD_W = 20;
  localparam int DEN_W         = (DENOM_BITS < DENOM_FIELD_W) ? DENOM_BITS : DENOM_FIELD_W;

  localparam int LIMB_W        = 31;
  localparam int QUOT_BITS     = 27;
  localparam int REM_W         = DENOM_BITS + QUOT_BITS;
  localparam int IDX_W         = $clog2(LIMB_COUNT);
  localparam int BIT_W         = $clog2(QUOT_BITS);

  localparam int OP_W          = 2;
  localparam int INDEX_FIELD_W = 6;
  localparam int IN_TDATA_W    = ((DENOM_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = INDEX_FIELD_W + LIMB_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [QUOT_BITS-1:0] LIMB_BASE = QUOT_BITS'(100000000);

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DV_START,
    ST_DV_STEP,
    ST_DV_MUL,
    ST_CY_RD,
    ST_CY_WR,
    ST_RD_ADDR,
    ST_RD_LOAD,
    ST_RD_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== sv/hsla_ram.sv =====
`default_nettype none

module hsla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/harmonic_sum_limb_accumulator.sv =====
// Add: each limb is divided in turn (address, 27 quotient bits, multiply and write),
// stopping once the remainder is zero or at the last limb, then a carry pass runs
// back down to limb 0. The bit-serial compare/subtract unit does the division.
// Readout: address, load and output per limb, holding while the sink stalls. Clear
// resets the per-limb valid bits. Reset (synchronous, rst_n low) clears them too, so
// the sum reads as zero at once; no item is accepted while an operation is in progress.
`default_nettype none

module harmonic_sum_limb_accumulator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hsla_pkg::IN_TDATA_W-1:0]   in_tdata,   // [19:0] denominator
  input  logic [hsla_pkg::OP_W-1:0]         in_tuser,   // [1:0] operation
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hsla_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [5:0] limb_index, [36:6] limb_value
  output logic                              out_tlast   // last_limb
);

  import hsla_pkg::*;

  state_t                 state_r, state_nxt;
  logic [DENOM_BITS-1:0]  den_r, den_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [REM_W-1:0]       dsh_r, dsh_nxt;
  logic [QUOT_BITS-1:0]   quot_r, quot_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  idx_t                   idx_r, idx_nxt;
  logic                   carry_r, carry_nxt;
  logic [LIMB_COUNT-1:0]  vld_r, vld_nxt;
  logic                   rd_vld_r;
  limb_t                  out_val_r, out_val_nxt;
  idx_t                   out_idx_r, out_idx_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   in_acc;
  logic [DENOM_BITS-1:0]  in_den;
  logic                   last_idx;

  logic                   ram_wr_en;
  limb_t                  ram_wr_data;
  logic                   ram_rd_en;
  limb_t                  ram_rd_data;
  limb_t                  old_limb;
  limb_t                  limb_sum;
  limb_t                  limb_inc;

  logic [REM_W-1:0]       sub_a, sub_b;
  logic [REM_W:0]         sub_diff;
  logic                   sub_ge;
  logic [REM_W-1:0]       prod;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_den     = DENOM_BITS'(in_tdata[DEN_W-1:0]);
  assign last_idx   = (idx_r == IDX_W'(LIMB_COUNT - 1));

  // Limbs never written since reset or clear read as zero
  assign old_limb   = rd_vld_r ? ram_rd_data : '0;
  assign limb_sum   = old_limb + LIMB_W'(quot_r);
  assign limb_inc   = old_limb + LIMB_W'(carry_r);

  // Shared compare/subtract: division step, or carry test against the limb base
  always_comb begin
    if (state_r == ST_CY_WR) begin
      sub_a = REM_W'(limb_inc);
      sub_b = REM_W'(LIMB_BASE);
    end else begin
      sub_a = rem_r;
      sub_b = dsh_r;
    end
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[REM_W];
  assign prod     = rem_r[DENOM_BITS-1:0] * LIMB_BASE;

  hsla_ram #(
    .WIDTH (LIMB_W),
    .DEPTH (LIMB_COUNT)
  ) u_limbs (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            OP_ADD: begin
              if (in_den != '0) begin
                state_nxt = ST_DV_START;
              end
            end
            OP_READ: state_nxt = ST_RD_ADDR;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DV_START: state_nxt = ST_DV_STEP;
      ST_DV_STEP: begin
        if (bit_r == '0) begin
          state_nxt = ST_DV_MUL;
        end
      end
      ST_DV_MUL: begin
        if (rem_r == '0 || last_idx) begin
          state_nxt = ST_CY_RD;
        end else begin
          state_nxt = ST_DV_START;
        end
      end
      ST_CY_RD: state_nxt = ST_CY_WR;
      ST_CY_WR: begin
        if (idx_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_CY_RD;
        end
      end
      ST_RD_ADDR: state_nxt = ST_RD_LOAD;
      ST_RD_LOAD: state_nxt = ST_RD_OUT;
      ST_RD_OUT: begin
        if (out_tready) begin
          state_nxt = out_last_r ? ST_IDLE : ST_RD_ADDR;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    quot_nxt      = quot_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    carry_nxt     = carry_r;
    vld_nxt       = vld_r;
    out_val_nxt   = out_val_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    ram_wr_en     = 1'b0;
    ram_wr_data   = limb_sum;
    ram_rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            OP_ADD: begin
              den_nxt = in_den;
              rem_nxt = REM_W'(1);
              idx_nxt = '0;
            end
            OP_READ:  idx_nxt = '0;
            OP_CLEAR: vld_nxt = '0;
            default:  idx_nxt = idx_r;
          endcase
        end
      end
      ST_DV_START: begin
        ram_rd_en = 1'b1;
        dsh_nxt   = REM_W'(den_r) << (QUOT_BITS - 1);
        quot_nxt  = '0;
        bit_nxt   = BIT_W'(QUOT_BITS - 1);
      end
      ST_DV_STEP: begin
        if (sub_ge) begin
          rem_nxt = sub_diff[REM_W-1:0];
        end
        quot_nxt = {quot_r[QUOT_BITS-2:0], sub_ge};
        dsh_nxt  = dsh_r >> 1;
        bit_nxt  = bit_r - BIT_W'(1);
      end
      ST_DV_MUL: begin
        ram_wr_en      = 1'b1;
        ram_wr_data    = limb_sum;
        vld_nxt[idx_r] = 1'b1;
        rem_nxt        = prod;
        carry_nxt      = 1'b0;
        if (!(rem_r == '0 || last_idx)) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_CY_RD: ram_rd_en = 1'b1;
      ST_CY_WR: begin
        ram_wr_en      = 1'b1;
        vld_nxt[idx_r] = 1'b1;
        if (idx_r == '0) begin
          // integer limb wraps at 2^31
          ram_wr_data = limb_inc;
        end else begin
          if (sub_ge) begin
            ram_wr_data = sub_diff[LIMB_W-1:0];
          end else begin
            ram_wr_data = limb_inc;
          end
          carry_nxt = sub_ge;
          idx_nxt   = idx_r - IDX_W'(1);
        end
      end
      ST_RD_ADDR: ram_rd_en = 1'b1;
      ST_RD_LOAD: begin
        out_val_nxt   = old_limb;
        out_idx_nxt   = idx_r;
        out_last_nxt  = last_idx;
        out_valid_nxt = 1'b1;
      end
      ST_RD_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          idx_nxt       = idx_r + IDX_W'(1);
        end
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    quot_r     <= quot_nxt;
    bit_r      <= bit_nxt;
    idx_r      <= idx_nxt;
    carry_r    <= carry_nxt;
    out_val_r  <= out_val_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    if (ram_rd_en) begin
      rd_vld_r <= vld_r[idx_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_val_r, INDEX_FIELD_W'(out_idx_r)});

endmodule

`default_nettype wire

// ===== sv/hsla_chk.sv =====
`default_nettype none

module hsla_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [hsla_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tlast
);

  import hsla_pkg::*;

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Never take a new item while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[INDEX_FIELD_W-1:0] == INDEX_FIELD_W'(LIMB_COUNT - 1))
    else $error("last limb flag on wrong index");

  // A readout run ends by returning to ready
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("not ready after last limb");

endmodule

bind harmonic_sum_limb_accumulator hsla_chk u_hsla_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
